>>> src/tcrm_pkg.sv
package tcrm_pkg;

  localparam int NSTATIONS_DEF = 16;
  localparam int LEVELS_DEF    = 5;

  localparam int CMD_W     = 2;
  localparam int STATION_W = 4;
  localparam int LEVEL_W   = 3;

  typedef enum logic [1:0] {
    CMD_START     = 2'd0,
    CMD_SUCCESS   = 2'd1,
    CMD_COLLISION = 2'd2,
    CMD_EMPTY     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC,
    PTR_DEPTH_M1
  } ptr_op_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CHECK,
    ACT_MARK,
    ACT_CLEAR,
    ACT_DESCEND,
    ACT_ADVANCE,
    ACT_END,
    ACT_OUTPUT
  } act_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_SKIP_CHECK,
    COND_CHECK_MORE,
    COND_CLEAR_MORE,
    COND_RUNNING,
    COND_DEPTH_ZERO,
    COND_ADV_MORE,
    COND_OUT_FREE
  } cond_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ST_INIT,
    S_ST_CHECK,
    S_ST_MARK,
    S_SU_INIT,
    S_SU_CLEAR,
    S_SU_NEXT,
    S_CO_DESC,
    S_EM_TEST,
    S_AD_INIT,
    S_AD_STEP,
    S_AD_END,
    S_FIN
  } step_t;

  typedef struct packed {
    ptr_op_t ptr_op;
    act_t    act;
    cond_t   cond;
    step_t   tgt_t;
    step_t   tgt_f;
  } uword_t;

  typedef struct packed {
    ptr_op_t ptr_op;
    act_t    act;
    logic    taken;
  } dp_ctrl_t;

  typedef struct packed {
    logic skip_check;
    logic check_more;
    logic clear_more;
    logic running;
    logic depth_zero;
    logic adv_more;
    logic out_free;
  } dp_flags_t;

  // Microprogram: one control word per step
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      S_ST_INIT:  w = '{PTR_ZERO,     ACT_NONE,    COND_SKIP_CHECK, S_ST_MARK,  S_ST_CHECK};
      S_ST_CHECK: w = '{PTR_INC,      ACT_CHECK,   COND_CHECK_MORE, S_ST_CHECK, S_ST_MARK};
      S_ST_MARK:  w = '{PTR_HOLD,     ACT_MARK,    COND_ALWAYS,     S_FIN,      S_FIN};
      S_SU_INIT:  w = '{PTR_ZERO,     ACT_NONE,    COND_ALWAYS,     S_SU_CLEAR, S_SU_CLEAR};
      S_SU_CLEAR: w = '{PTR_INC,      ACT_CLEAR,   COND_CLEAR_MORE, S_SU_CLEAR, S_SU_NEXT};
      S_SU_NEXT:  w = '{PTR_HOLD,     ACT_NONE,    COND_RUNNING,    S_AD_INIT,  S_FIN};
      S_CO_DESC:  w = '{PTR_HOLD,     ACT_DESCEND, COND_ALWAYS,     S_FIN,      S_FIN};
      S_EM_TEST:  w = '{PTR_HOLD,     ACT_NONE,    COND_RUNNING,    S_AD_INIT,  S_FIN};
      S_AD_INIT:  w = '{PTR_DEPTH_M1, ACT_NONE,    COND_DEPTH_ZERO, S_AD_END,   S_AD_STEP};
      S_AD_STEP:  w = '{PTR_DEC,      ACT_ADVANCE, COND_ADV_MORE,   S_AD_STEP,  S_FIN};
      S_AD_END:   w = '{PTR_HOLD,     ACT_END,     COND_ALWAYS,     S_FIN,      S_FIN};
      S_FIN:      w = '{PTR_HOLD,     ACT_OUTPUT,  COND_OUT_FREE,   S_IDLE,     S_FIN};
      default:    w = '{PTR_HOLD,     ACT_NONE,    COND_ALWAYS,     S_IDLE,     S_IDLE};
    endcase
    return w;
  endfunction

  function automatic step_t entry(cmd_t c);
    step_t s;
    case (c)
      CMD_START:     s = S_ST_INIT;
      CMD_SUCCESS:   s = S_SU_INIT;
      CMD_COLLISION: s = S_CO_DESC;
      CMD_EMPTY:     s = S_EM_TEST;
      default:       s = S_IDLE;
    endcase
    return s;
  endfunction

endpackage

>>> src/tcrm_in_if.sv
interface tcrm_in_if import tcrm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [STATION_W-1:0] station;

  modport source (output valid, cmd, station, input ready);
  modport sink   (input valid, cmd, station, output ready);
endinterface

>>> src/tcrm_out_if.sv
interface tcrm_out_if import tcrm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               illegal_transmission;
  logic               unknown_player;
  logic               players_left_behind;
  logic               depth_overflow;
  logic               tournament_active;
  logic [LEVEL_W-1:0] tree_level;

  modport source (output valid, illegal_transmission, unknown_player, players_left_behind,
                  depth_overflow, tournament_active, tree_level, input ready);
  modport sink   (input valid, illegal_transmission, unknown_player, players_left_behind,
                  depth_overflow, tournament_active, tree_level, output ready);
endinterface

>>> src/tcrm_cfg_if.sv
interface tcrm_cfg_if;
  logic valid;
  logic ready;
  logic left_bit;

  modport source (output valid, left_bit, input ready);
  modport sink   (input valid, left_bit, output ready);
endinterface

>>> src/tcrm_seq.sv
module tcrm_seq import tcrm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  cmd_t      cmd,
  input  dp_flags_t flags,
  output dp_ctrl_t  ctrl,
  output logic      idle
);

  step_t  pc_r, pc_nxt;
  uword_t uw;
  logic   taken;

  always_comb begin
    uw = ucode(pc_r);
    case (uw.cond)
      COND_ALWAYS:     taken = 1'b1;
      COND_SKIP_CHECK: taken = flags.skip_check;
      COND_CHECK_MORE: taken = flags.check_more;
      COND_CLEAR_MORE: taken = flags.clear_more;
      COND_RUNNING:    taken = flags.running;
      COND_DEPTH_ZERO: taken = flags.depth_zero;
      COND_ADV_MORE:   taken = flags.adv_more;
      COND_OUT_FREE:   taken = flags.out_free;
      default:         taken = 1'b0;
    endcase
    if (pc_r == S_IDLE) begin
      pc_nxt = accept ? entry(cmd) : S_IDLE;
    end else begin
      pc_nxt = taken ? uw.tgt_t : uw.tgt_f;
    end
  end

  assign ctrl = '{ptr_op: uw.ptr_op, act: uw.act, taken: taken};
  assign idle = (pc_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> src/tcrm_dp.sv
module tcrm_dp import tcrm_pkg::*; #(
  parameter int NSTATIONS = NSTATIONS_DEF,
  parameter int LEVELS    = LEVELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [STATION_W-1:0] station,
  input  logic                 cfg_we,
  input  logic                 cfg_left_bit,
  input  dp_ctrl_t             ctrl,
  output dp_flags_t            flags,
  tcrm_out_if.source           out_if
);

  localparam int DW = $clog2(LEVELS + 1);
  localparam int IW = $clog2(LEVELS);

  logic [DW-1:0]        ptr_r, depth_r;
  logic                 running_r;
  logic                 left_r;
  logic [LEVELS-1:0]    branch_r;
  logic [NSTATIONS-1:0] marks_r [LEVELS];
  logic [STATION_W-1:0] station_r;
  logic                 illegal_r, unknown_r, behind_r, overflow_r;
  logic                 out_valid_r;
  logic                 out_illegal_r, out_unknown_r, out_behind_r, out_overflow_r;
  logic                 out_active_r;
  logic [LEVEL_W-1:0]   out_level_r;

  logic [IW-1:0]        ptr_idx, depth_idx;
  logic                 ptr_in;
  logic [NSTATIONS-1:0] marks_at, mask;
  logic                 branch_at, st_bit;

  assign ptr_idx   = ptr_r[IW-1:0];
  assign depth_idx = depth_r[IW-1:0];
  assign ptr_in    = 32'(ptr_r) < LEVELS;
  assign marks_at  = ptr_in ? marks_r[ptr_idx] : '0;
  assign branch_at = ptr_in ? branch_r[ptr_idx] : 1'b0;
  // address bits above the station field read as zero
  assign st_bit    = (32'(ptr_r) < STATION_W) ? station_r[ptr_r[1:0]] : 1'b0;

  always_comb begin
    for (int i = 0; i < NSTATIONS; i++) begin
      mask[i] = (32'(station_r) == i);
    end
  end

  always_comb begin
    flags.skip_check = !running_r || (depth_r == '0);
    flags.check_more = (32'(ptr_r) + 1) < 32'(depth_r);
    flags.clear_more = (ptr_r < depth_r) && ((32'(ptr_r) + 1) < LEVELS);
    flags.running    = running_r;
    flags.depth_zero = (depth_r == '0);
    flags.adv_more   = (branch_at != left_r) && (ptr_r != '0);
    flags.out_free   = !out_valid_r || out_if.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      depth_r     <= '0;
      running_r   <= 1'b0;
      left_r      <= 1'b0;
      branch_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        marks_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        left_r <= cfg_left_bit;
      end
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        station_r  <= station;
        illegal_r  <= 1'b0;
        unknown_r  <= 1'b0;
        behind_r   <= 1'b0;
        overflow_r <= 1'b0;
      end

      case (ctrl.ptr_op)
        PTR_ZERO:     ptr_r <= '0;
        PTR_INC:      ptr_r <= ptr_r + 1'b1;
        PTR_DEC:      ptr_r <= ptr_r - 1'b1;
        PTR_DEPTH_M1: ptr_r <= depth_r - 1'b1;
        default:      ptr_r <= ptr_r;
      endcase

      case (ctrl.act)
        ACT_CHECK: begin
          if (st_bit != branch_at) illegal_r <= 1'b1;
        end
        ACT_MARK: begin
          if (ptr_in) marks_r[ptr_idx] <= marks_at | mask;
        end
        ACT_CLEAR: begin
          if (ptr_in && (mask != '0) && ((marks_at & mask) != '0)) begin
            marks_r[ptr_idx] <= marks_at & ~mask;
          end else begin
            unknown_r <= 1'b1;
          end
        end
        ACT_DESCEND: begin
          if (32'(depth_r) >= LEVELS) begin
            overflow_r <= 1'b1;
          end else begin
            branch_r[depth_idx] <= left_r;
            depth_r             <= depth_r + 1'b1;
            running_r           <= 1'b1;
          end
        end
        ACT_ADVANCE: begin
          // turn a left branch right, otherwise pop this level
          if (branch_at == left_r) begin
            branch_r[ptr_idx] <= ~left_r;
          end else begin
            depth_r <= ptr_r;
            if (marks_at != '0) behind_r <= 1'b1;
            if (ptr_r == '0) running_r <= 1'b0;
          end
        end
        ACT_END: begin
          running_r <= 1'b0;
          depth_r   <= '0;
        end
        ACT_OUTPUT: begin
          if (ctrl.taken) begin
            out_valid_r    <= 1'b1;
            out_illegal_r  <= illegal_r;
            out_unknown_r  <= unknown_r;
            out_behind_r   <= behind_r;
            out_overflow_r <= overflow_r;
            out_active_r   <= running_r;
            out_level_r    <= LEVEL_W'(depth_r);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_if.valid                = out_valid_r;
  assign out_if.illegal_transmission = out_illegal_r;
  assign out_if.unknown_player       = out_unknown_r;
  assign out_if.players_left_behind  = out_behind_r;
  assign out_if.depth_overflow       = out_overflow_r;
  assign out_if.tournament_active    = out_active_r;
  assign out_if.tree_level           = out_level_r;

endmodule

>>> src/tree_collision_resolution_monitor_unit.sv
// Tree collision resolution monitor.
// in_if carries one channel event per transfer (cmd, station); out_if returns
// one result per event with the rule-break flags and the tree state after it.
// cfg_if writes left_bit, the address bit value of a left branch; it is always
// ready. The user must write it only while no event is in flight; the block
// itself has no check for this. A small microprogram steps one tree level per
// cycle through a single level pointer. in_ready is high only while the
// sequencer sits idle, so one event is handled at a time.
// Results go to an output register: the next event is accepted while a
// result still waits, and a stalled receiver holds the sequencer in its final
// step until the register frees up, so nothing is lost.
// Reset (rst_n low at a clock edge) clears the tree depth, the tournament
// flag, all branch bits, all player marks and left_bit at once.
module tree_collision_resolution_monitor_unit import tcrm_pkg::*; #(
  parameter int NSTATIONS = NSTATIONS_DEF,
  parameter int LEVELS    = LEVELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tcrm_in_if.sink    in_if,
  tcrm_out_if.source out_if,
  tcrm_cfg_if.sink   cfg_if
);

  logic      idle;
  logic      accept;
  dp_ctrl_t  ctrl;
  dp_flags_t flags;

  assign in_if.ready  = idle;
  assign accept       = in_if.valid && idle;
  assign cfg_if.ready = 1'b1;

  tcrm_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .cmd    (cmd_t'(in_if.cmd)),
    .flags  (flags),
    .ctrl   (ctrl),
    .idle   (idle)
  );

  tcrm_dp #(
    .NSTATIONS (NSTATIONS),
    .LEVELS    (LEVELS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .station      (in_if.station),
    .cfg_we       (cfg_if.valid),
    .cfg_left_bit (cfg_if.left_bit),
    .ctrl         (ctrl),
    .flags        (flags),
    .out_if       (out_if)
  );

  // a tournament runs exactly when the tree is below level zero
  a_running_depth: assert property (@(posedge clk) disable iff (!rst_n)
    flags.running == !flags.depth_zero)
    else $error("tournament flag disagrees with tree depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_if.ready)
    else $error("input ready while an event is in flight");

  a_out_active_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.tournament_active == (out_if.tree_level != '0)))
    else $error("result tournament flag disagrees with tree level");

  a_out_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (32'(out_if.tree_level) <= LEVELS))
    else $error("result tree level beyond deepest level");

endmodule

>>> test/tb_tree_collision_resolution_monitor_unit.sv
module tb_tree_collision_resolution_monitor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tcrm_pkg::*;

  localparam int NST            = NSTATIONS_DEF;
  localparam int LVL            = LEVELS_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 20;
  localparam int RANDOM_EVENTS  = 500;

  typedef struct packed {
    logic               illegal;
    logic               unknown;
    logic               behind;
    logic               overflow;
    logic               active;
    logic [LEVEL_W-1:0] level;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;

  tcrm_in_if  in_ch ();
  tcrm_out_if out_ch ();
  tcrm_cfg_if cfg_ch ();

  tree_collision_resolution_monitor_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the monitor's tree state
  logic           left_sel;
  logic           branch[LVL];
  logic [NST-1:0] marks[LVL];
  int             tree_depth;
  logic           in_tournament;

  verdict_t expected_verdicts[$];
  bit       steady_flow;
  int       fail_count;
  int       events_sent;
  int       random_sent;
  int       results_seen;
  int       illegal_seen, unknown_seen, behind_seen, overflow_seen;
  int       idle_cycles;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Turn a left branch right, or pop levels until one can turn or the tree empties
  function automatic bit advance_tree();
    bit left_behind;
    bit done;
    left_behind = 1'b0;
    done        = 1'b0;
    while (!done) begin
      if (tree_depth == 0) begin
        in_tournament = 1'b0;
        done          = 1'b1;
      end else if (branch[tree_depth-1] == left_sel) begin
        branch[tree_depth-1] = ~left_sel;
        done                 = 1'b1;
      end else begin
        tree_depth--;
        if (marks[tree_depth] != '0) left_behind = 1'b1;
        if (tree_depth == 0) begin
          in_tournament = 1'b0;
          done          = 1'b1;
        end
      end
    end
    return left_behind;
  endfunction

  task automatic tree_predict(input cmd_t c, input logic [STATION_W-1:0] st,
                              output verdict_t v);
    logic [NST-1:0] m;
    logic [7:0]     path;
    v    = '0;
    m    = NST'(1) << st;
    path = 8'(st);
    case (c)
      CMD_START: begin
        if (in_tournament) begin
          for (int lv = 0; lv < tree_depth && lv < LVL; lv++)
            if (path[lv] != branch[lv]) v.illegal = 1'b1;
        end
        if (tree_depth < LVL) marks[tree_depth] |= m;
      end
      CMD_SUCCESS: begin
        for (int lv = 0; lv <= tree_depth && lv < LVL; lv++) begin
          if ((marks[lv] & m) != '0) marks[lv] &= ~m;
          else v.unknown = 1'b1;
        end
        if (in_tournament) v.behind = advance_tree();
      end
      CMD_COLLISION: begin
        if (tree_depth >= LVL) begin
          v.overflow = 1'b1;
        end else begin
          branch[tree_depth] = left_sel;
          tree_depth++;
          in_tournament = 1'b1;
        end
      end
      default: begin
        if (in_tournament) v.behind = advance_tree();
      end
    endcase
    v.active = in_tournament;
    v.level  = LEVEL_W'(tree_depth);
  endtask

  // Called at a falling edge; returns at a falling edge
  task automatic send_event(input cmd_t c, input logic [STATION_W-1:0] st);
    verdict_t v;
    int       gap;
    in_ch.valid   = 1'b1;
    in_ch.cmd     = c;
    in_ch.station = st;
    do @(posedge clk); while (!in_ch.ready);
    tree_predict(c, st, v);
    expected_verdicts.push_back(v);
    events_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
    gap = steady_flow ? 0 : pick_gap();
    repeat (gap) @(negedge clk);
  endtask

  task automatic drain_results();
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_left_bit(input logic val);
    cfg_ch.valid    = 1'b1;
    cfg_ch.left_bit = val;
    do @(posedge clk); while (!cfg_ch.ready);
    left_sel = val;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic finish_tournament();
    int guard;
    guard = 0;
    while (in_tournament && guard < 4 * LVL) begin
      send_event(CMD_EMPTY, 4'($urandom_range(0, NST - 1)));
      guard++;
    end
  endtask

  function automatic logic [STATION_W-1:0] pick_player();
    logic [STATION_W-1:0] cands[$];
    for (int lv = 0; lv <= tree_depth && lv < LVL; lv++)
      for (int s = 0; s < NST; s++)
        if (marks[lv][s]) cands.push_back(STATION_W'(s));
    if (cands.size() == 0) return STATION_W'($urandom_range(0, NST - 1));
    return cands[$urandom_range(0, cands.size() - 1)];
  endfunction

  function automatic logic [STATION_W-1:0] pick_on_path();
    logic [STATION_W-1:0] s;
    s = STATION_W'($urandom_range(0, NST - 1));
    for (int lv = 0; lv < tree_depth && lv < STATION_W; lv++) s[lv] = branch[lv];
    return s;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Events outside a tournament: ignored empty slot, unknown players, unchecked starts
  task automatic test_idle_events();
    send_event(CMD_EMPTY, 4'd0);
    send_event(CMD_SUCCESS, 4'd15);
    send_event(CMD_START, 4'd0);
    send_event(CMD_START, 4'd15);
    send_event(CMD_SUCCESS, 4'd0);
    send_event(CMD_SUCCESS, 4'd15);
  endtask

  // Descend to the deepest level, overflow, path checks, then unwind
  task automatic test_deep_descent();
    repeat (3) send_event(CMD_COLLISION, 4'd0);
    send_event(CMD_START, 4'd5);
    send_event(CMD_START, 4'd8);
    repeat (2) send_event(CMD_COLLISION, 4'd15);
    send_event(CMD_COLLISION, 4'd3);
    send_event(CMD_START, 4'd15);
    send_event(CMD_START, 4'd0);
    send_event(CMD_EMPTY, 4'd0);
    // station bit above its width reads as zero against a right branch
    send_event(CMD_START, 4'd0);
    send_event(CMD_SUCCESS, 4'd8);
    finish_tournament();
  endtask

  // Both left_bit settings, including a change while a tournament runs
  task automatic test_left_bit();
    drain_results();
    write_left_bit(1'b1);
    send_event(CMD_COLLISION, 4'd0);
    send_event(CMD_START, 4'd1);
    send_event(CMD_EMPTY, 4'd9);
    send_event(CMD_START, 4'd1);
    drain_results();
    write_left_bit(1'b0);
    send_event(CMD_EMPTY, 4'd0);
    send_event(CMD_SUCCESS, 4'd1);
    finish_tournament();
    drain_results();
    write_left_bit(1'b1);
  endtask

  // Mostly protocol-shaped traffic with random content, some noise
  task automatic test_random_traffic(input int total);
    int   r;
    cmd_t c;
    logic [STATION_W-1:0] st;
    for (int i = 0; i < total; i++) begin
      if (i % 60 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      if (i > 0 && i % 125 == 0) begin
        drain_results();
        write_left_bit(1'($urandom_range(0, 1)));
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        c  = cmd_t'($urandom_range(0, 3));
        st = STATION_W'($urandom_range(0, NST - 1));
      end else if (in_tournament) begin
        if (r < 28) begin
          c  = CMD_COLLISION;
          st = STATION_W'($urandom_range(0, NST - 1));
        end else if (r < 55) begin
          c  = CMD_EMPTY;
          st = STATION_W'($urandom_range(0, NST - 1));
        end else if (r < 78) begin
          c  = CMD_START;
          st = pick_on_path();
        end else begin
          c  = CMD_SUCCESS;
          st = pick_player();
        end
      end else begin
        if (r < 45) begin
          c  = CMD_COLLISION;
          st = STATION_W'($urandom_range(0, NST - 1));
        end else if (r < 78) begin
          c  = CMD_START;
          st = STATION_W'($urandom_range(0, NST - 1));
        end else begin
          c  = CMD_SUCCESS;
          st = pick_player();
        end
      end
      send_event(c, st);
      random_sent++;
    end
    steady_flow = 1'b0;
  endtask

  // Receiver stalls
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      out_ch.ready = 1'b1;
      repeat (1 + $urandom_range(0, 6)) @(negedge clk);
      if (!steady_flow) begin
        out_ch.ready = 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_result
    verdict_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (expected_verdicts.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result with no event outstanding, expected none, actual level %0d",
                   $time, out_ch.tree_level);
      end else begin
        want = expected_verdicts.pop_front();
        compare_field("illegal_transmission", want.illegal, out_ch.illegal_transmission);
        compare_field("unknown_player", want.unknown, out_ch.unknown_player);
        compare_field("players_left_behind", want.behind, out_ch.players_left_behind);
        compare_field("depth_overflow", want.overflow, out_ch.depth_overflow);
        compare_field("tournament_active", want.active, out_ch.tournament_active);
        compare_field("tree_level", want.level, out_ch.tree_level);
        illegal_seen  += want.illegal;
        unknown_seen  += want.unknown;
        behind_seen   += want.behind;
        overflow_seen += want.overflow;
      end
    end
  end

  // Stop if nothing transfers on any channel for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_START;
    in_ch.station   = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.left_bit = 1'b0;
    steady_flow     = 1'b0;
    fail_count      = 0;
    events_sent     = 0;
    random_sent     = 0;
    results_seen    = 0;
    illegal_seen    = 0;
    unknown_seen    = 0;
    behind_seen     = 0;
    overflow_seen   = 0;
    idle_cycles     = 0;
    left_sel        = 1'b0;
    tree_depth      = 0;
    in_tournament   = 1'b0;
    for (int lv = 0; lv < LVL; lv++) begin
      branch[lv] = 1'b0;
      marks[lv]  = '0;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_events();
    test_deep_descent();
    test_left_bit();
    test_random_traffic(RANDOM_EVENTS);

    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);

    $display("Ran %0d events (%0d random) with left_bit changes, %0d results checked.",
             events_sent, random_sent, results_seen);
    $display("Flags raised: %0d illegal, %0d unknown, %0d left behind, %0d overflow.",
             illegal_seen, unknown_seen, behind_seen, overflow_seen);
    if (fail_count == 0 && expected_verdicts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
